// File: rtl/albc_pkg.sv
// shared types, constants and codes of the ambient light backlight controller
// no dependencies; used by all rtl files of the block
package albc_pkg;

  // defaults of the top level parameters
  localparam int unsigned LIGHT_BITS_DEF   = 24;
  localparam int unsigned STEP_PERCENT_DEF = 5;

  // field and register widths
  localparam int unsigned ACT_W      = 3;
  localparam int unsigned EXT_W      = 7;
  localparam int unsigned LEVEL_W    = 15;
  localparam int unsigned PCT_W      = 7;
  localparam int unsigned GAIN_W     = 17;
  localparam int unsigned TICK_W     = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 17;

  // shared multiply / divide unit: accumulator high part covers lights up to 32 bits
  localparam int unsigned ACC_HI_W = 33;
  localparam int unsigned MUL_B_W  = 17;
  localparam int unsigned P_W      = ACC_HI_W + MUL_B_W;
  localparam int unsigned Q_W      = 16;
  localparam int unsigned SUM_W    = ACC_HI_W + 1;

  // levels are q7.8 percent
  localparam logic [LEVEL_W-1:0]  FULL_LEVEL    = 15'd25600;
  localparam logic [LEVEL_W-1:0]  ONE_PERCENT   = 15'd256;
  localparam logic [EXT_W-1:0]    PCT_MAX       = 7'd100;
  localparam logic [GAIN_W-1:0]   GAIN_ONE      = 17'h10000;
  localparam logic [GAIN_W-1:0]   GAIN_RESET    = 17'd6554;
  localparam logic [TICK_W-1:0]   HOLDOFF_RESET = 16'd1000;
  localparam logic [TICK_W-1:0]   TICK_MAX      = 16'hFFFF;
  localparam logic [ACC_HI_W-1:0] ROUND_HALF    = 33'd32768;

  // action codes
  localparam logic [ACT_W-1:0] ACT_SAMPLE    = 3'd0;
  localparam logic [ACT_W-1:0] ACT_STEP_UP   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_STEP_DOWN = 3'd2;
  localparam logic [ACT_W-1:0] ACT_EXTERNAL  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_TICK      = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF = 2'd1;

  typedef enum logic {
    OP_MAC = 1'b0,
    OP_DIV = 1'b1
  } op_t;

  // command to the arithmetic unit
  typedef struct packed {
    logic                start;
    op_t                 op;
    logic [ACC_HI_W-1:0] acc_init;
    logic [ACC_HI_W-1:0] opnd;
    logic [MUL_B_W-1:0]  mul_b;
  } cmd_t;

  // status back from the arithmetic unit
  typedef struct packed {
    logic           done;
    logic           ovf;
    logic [P_W-1:0] prod;
  } sts_t;

endpackage

// File: rtl/albc_muldiv.sv
// iterative multiply-accumulate and restoring divide around one shared adder
// depends on albc_pkg
module albc_muldiv (
  input  logic           clk,
  input  logic           rst_n,
  input  albc_pkg::cmd_t cmd,
  output albc_pkg::sts_t sts
);
  import albc_pkg::*;

  localparam int unsigned CNT_W = $clog2(MUL_B_W + 1);

  typedef enum logic [3:0] {
    U_IDLE = 4'b0001,
    U_MAC  = 4'b0010,
    U_CHK  = 4'b0100,
    U_DIV  = 4'b1000
  } ustate_t;

  ustate_t             st_r, st_nxt;
  logic [P_W-1:0]      p_r, p_nxt;
  logic [ACC_HI_W-1:0] opnd_r, opnd_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                done_r, done_nxt;
  logic                ovf_r, ovf_nxt;

  logic [P_W-1:0]      sh;
  logic [ACC_HI_W-1:0] add_x, add_y;
  logic                add_sub;
  logic [SUM_W-1:0]    add_res;

  // shared adder, subtract mode gives borrow in the top bit
  always_comb begin
    sh      = {p_r[P_W-2:0], 1'b0};
    add_x   = p_r[P_W-1:MUL_B_W];
    add_y   = p_r[0] ? opnd_r : '0;
    add_sub = 1'b0;
    case (st_r)
      U_CHK: begin
        add_x   = p_r[P_W-2:Q_W];
        add_y   = opnd_r;
        add_sub = 1'b1;
      end
      U_DIV: begin
        add_x   = sh[P_W-2:Q_W];
        add_y   = opnd_r;
        add_sub = 1'b1;
      end
      default: ;
    endcase
    add_res = {1'b0, add_x} + (add_sub ? ~{1'b0, add_y} : {1'b0, add_y})
              + {{(SUM_W-1){1'b0}}, add_sub};
  end

  always_comb begin
    st_nxt   = st_r;
    p_nxt    = p_r;
    opnd_nxt = opnd_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    ovf_nxt  = ovf_r;
    case (st_r)
      U_MAC: begin
        p_nxt   = {add_res, p_r[MUL_B_W-1:1]};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          done_nxt = 1'b1;
          st_nxt   = U_IDLE;
        end
      end
      U_CHK: begin
        if (!add_res[SUM_W-1]) begin
          // quotient would not fit
          ovf_nxt  = 1'b1;
          done_nxt = 1'b1;
          st_nxt   = U_IDLE;
        end else begin
          cnt_nxt = CNT_W'(Q_W);
          st_nxt  = U_DIV;
        end
      end
      U_DIV: begin
        if (!add_res[SUM_W-1]) begin
          p_nxt = {sh[P_W-1], add_res[ACC_HI_W-1:0], sh[Q_W-1:1], 1'b1};
        end else begin
          p_nxt = sh;
        end
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          done_nxt = 1'b1;
          st_nxt   = U_IDLE;
        end
      end
      default: ;
    endcase
    if (cmd.start) begin
      opnd_nxt = cmd.opnd;
      ovf_nxt  = 1'b0;
      if (cmd.op == OP_MAC) begin
        p_nxt   = {cmd.acc_init, cmd.mul_b};
        cnt_nxt = CNT_W'(MUL_B_W);
        st_nxt  = U_MAC;
      end else begin
        st_nxt = U_CHK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= U_IDLE;
      cnt_r  <= '0;
      done_r <= 1'b0;
      ovf_r  <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
      ovf_r  <= ovf_nxt;
    end
    p_r    <= p_nxt;
    opnd_r <= opnd_nxt;
  end

  assign sts.done = done_r;
  assign sts.ovf  = ovf_r;
  assign sts.prod = p_r;

endmodule

// File: rtl/ambient_light_backlight_controller_top.sv
// top level of the ambient light backlight controller
// depends on albc_pkg and albc_muldiv
//
// Follows ambient light with the panel backlight. Each request carries an action: light
// sample, step up, step down, external level change or time tick, and gives exactly one
// response with the write flag, the held level in whole percent and the moving average
// in q7.8 percent. A light sample after reset or after a step or external change makes
// that sample the reference; the target is light * reference level / reference light,
// capped at 100 %, and the average moves toward it by smoothing_gain (q1.16, round half
// up). A light sample makes four passes through one shared 33-bit adder (17-step
// multiply, restoring divide, two 17-step multiply-accumulates for the average); with a
// zero reference light the multiply and divide are skipped. in_ready is high only while
// no request is in progress; a finished response waits in the output register and the
// next request is taken while it waits. A request that finishes while an earlier
// response still waits holds in its last state, and keeps in_ready low, until out_ready
// frees the output register.
// Configuration writes are always ready and should be issued only while idle.
module ambient_light_backlight_controller_top #(
  parameter int unsigned LIGHT_BITS   = albc_pkg::LIGHT_BITS_DEF,
  parameter int unsigned STEP_PERCENT = albc_pkg::STEP_PERCENT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // request channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [albc_pkg::ACT_W-1:0]      in_action,
  input  logic [LIGHT_BITS-1:0]           in_light_level,
  input  logic [albc_pkg::EXT_W-1:0]      in_external_level,
  // response channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_write_level,
  output logic [albc_pkg::PCT_W-1:0]      out_backlight_percent,
  output logic [albc_pkg::LEVEL_W-1:0]    out_smoothed_target,
  // configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [albc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [albc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import albc_pkg::*;

  // step size in q7.8
  localparam logic [LEVEL_W-1:0] STEP_Q = LEVEL_W'(STEP_PERCENT * 256);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_PREP = 8'b0000_0010,
    ST_MUL  = 8'b0000_0100,
    ST_DIV  = 8'b0000_1000,
    ST_EMAG = 8'b0001_0000,
    ST_EMA1 = 8'b0010_0000,
    ST_EMA2 = 8'b0100_0000,
    ST_FIN  = 8'b1000_0000
  } state_t;

  state_t              st_r, st_nxt;
  logic [GAIN_W-1:0]   gain_r, gain_nxt;
  logic [TICK_W-1:0]   holdoff_r, holdoff_nxt;
  logic [LEVEL_W-1:0]  avg_r, avg_nxt;
  logic [LEVEL_W-1:0]  held_r, held_nxt;
  logic [LIGHT_BITS-1:0] ref_light_r, ref_light_nxt;
  logic [LEVEL_W-1:0]  ref_level_r, ref_level_nxt;
  logic                pending_r, pending_nxt;
  logic [TICK_W-1:0]   ticks_r, ticks_nxt;
  logic [LIGHT_BITS-1:0] light_r, light_nxt;
  logic [LEVEL_W-1:0]  target_r, target_nxt;
  logic                wr_r, wr_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_wr_r, out_wr_nxt;
  logic [PCT_W-1:0]    out_pct_r, out_pct_nxt;
  logic [LEVEL_W-1:0]  out_avg_r, out_avg_nxt;

  cmd_t cmd;
  sts_t sts;

  // step and external level candidates
  logic [LEVEL_W:0]           up_sum;
  logic [LEVEL_W-1:0]         up_lvl, dn_lvl, ext_lvl;
  logic [EXT_W-1:0]           ext_pct;
  // divide and average results
  logic [Q_W-1:0]             quo;
  logic [LEVEL_W-1:0]         div_tgt;
  logic [P_W-Q_W-1:0]         avg_full;
  logic [LEVEL_W-1:0]         avg_new;

  // true when two levels are at least one percent apart
  function automatic logic moves_enough(input logic [LEVEL_W-1:0] a,
                                        input logic [LEVEL_W-1:0] b);
    logic [LEVEL_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return d >= ONE_PERCENT;
  endfunction

  albc_muldiv u_muldiv (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (cmd),
    .sts  (sts)
  );

  always_comb begin
    up_sum  = {1'b0, held_r} + {1'b0, STEP_Q};
    up_lvl  = (up_sum > {1'b0, FULL_LEVEL}) ? FULL_LEVEL : up_sum[LEVEL_W-1:0];
    dn_lvl  = (held_r >= STEP_Q) ? (held_r - STEP_Q) : '0;
    ext_pct = (in_external_level > PCT_MAX) ? PCT_MAX : in_external_level;
    ext_lvl = {ext_pct, 8'd0};

    // quotient saturates at full level, as does a divide overflow
    quo      = sts.prod[Q_W-1:0];
    div_tgt  = (sts.ovf || quo > {1'b0, FULL_LEVEL}) ? FULL_LEVEL : quo[LEVEL_W-1:0];
    // average is the accumulator shifted down by 16
    avg_full = sts.prod[P_W-1:Q_W];
    avg_new  = (avg_full > (P_W-Q_W)'(FULL_LEVEL)) ? FULL_LEVEL : avg_full[LEVEL_W-1:0];
  end

  // commands to the shared unit
  always_comb begin
    cmd = '0;
    case (st_r)
      ST_PREP: begin
        if (ref_light_r != '0) begin
          // light times reference level
          cmd.start    = 1'b1;
          cmd.op       = OP_MAC;
          cmd.acc_init = '0;
          cmd.opnd     = ACC_HI_W'(light_r);
          cmd.mul_b    = MUL_B_W'(ref_level_r);
        end
      end
      ST_MUL: begin
        if (sts.done) begin
          cmd.start = 1'b1;
          cmd.op    = OP_DIV;
          cmd.opnd  = ACC_HI_W'(ref_light_r);
        end
      end
      ST_EMAG: begin
        // rounding constant plus gain times target
        cmd.start    = 1'b1;
        cmd.op       = OP_MAC;
        cmd.acc_init = ROUND_HALF;
        cmd.opnd     = ACC_HI_W'(target_r);
        cmd.mul_b    = gain_r;
      end
      ST_EMA1: begin
        if (sts.done) begin
          // add the complementary weight times the old average
          cmd.start    = 1'b1;
          cmd.op       = OP_MAC;
          cmd.acc_init = sts.prod[ACC_HI_W-1:0];
          cmd.opnd     = ACC_HI_W'(avg_r);
          cmd.mul_b    = GAIN_ONE - gain_r;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    st_nxt        = st_r;
    gain_nxt      = gain_r;
    holdoff_nxt   = holdoff_r;
    avg_nxt       = avg_r;
    held_nxt      = held_r;
    ref_light_nxt = ref_light_r;
    ref_level_nxt = ref_level_r;
    pending_nxt   = pending_r;
    ticks_nxt     = ticks_r;
    light_nxt     = light_r;
    target_nxt    = target_r;
    wr_nxt        = wr_r;
    out_valid_nxt = out_valid_r;
    out_wr_nxt    = out_wr_r;
    out_pct_nxt   = out_pct_r;
    out_avg_nxt   = out_avg_r;

    // configuration writes, gain saturates at one
    if (cfg_valid) begin
      case (cfg_index)
        CFG_GAIN:    gain_nxt = (cfg_data > GAIN_ONE) ? GAIN_ONE : cfg_data;
        CFG_HOLDOFF: holdoff_nxt = cfg_data[TICK_W-1:0];
        default: ;
      endcase
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (st_r)
      ST_IDLE: begin
        if (in_valid) begin
          wr_nxt = 1'b0;
          st_nxt = ST_FIN;
          case (in_action)
            ACT_SAMPLE: begin
              light_nxt = in_light_level;
              // pending renormalize: this sample becomes the reference
              if (pending_r) begin
                avg_nxt       = held_r;
                ref_light_nxt = in_light_level;
                ref_level_nxt = held_r;
                pending_nxt   = 1'b0;
              end
              st_nxt = ST_PREP;
            end
            ACT_STEP_UP: begin
              if (moves_enough(up_lvl, held_r)) begin
                held_nxt  = up_lvl;
                ticks_nxt = '0;
                wr_nxt    = 1'b1;
              end
              pending_nxt = 1'b1;
            end
            ACT_STEP_DOWN: begin
              if (moves_enough(dn_lvl, held_r)) begin
                held_nxt  = dn_lvl;
                ticks_nxt = '0;
                wr_nxt    = 1'b1;
              end
              pending_nxt = 1'b1;
            end
            ACT_EXTERNAL: begin
              // ignored inside the hold-off window after our own write
              if (ticks_r >= holdoff_r) begin
                held_nxt    = ext_lvl;
                pending_nxt = 1'b1;
              end
            end
            ACT_TICK: begin
              if (ticks_r != TICK_MAX) begin
                ticks_nxt = ticks_r + 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_PREP: begin
        if (ref_light_r == '0) begin
          // no reference light: full level
          target_nxt = FULL_LEVEL;
          st_nxt     = ST_EMAG;
        end else begin
          st_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        if (sts.done) begin
          st_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts.done) begin
          target_nxt = div_tgt;
          st_nxt     = ST_EMAG;
        end
      end
      ST_EMAG: begin
        st_nxt = ST_EMA1;
      end
      ST_EMA1: begin
        if (sts.done) begin
          st_nxt = ST_EMA2;
        end
      end
      ST_EMA2: begin
        if (sts.done) begin
          avg_nxt = avg_new;
          if (moves_enough(avg_new, held_r)) begin
            held_nxt  = avg_new;
            ticks_nxt = '0;
            wr_nxt    = 1'b1;
          end
          st_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        // hand over once the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_wr_nxt    = wr_r;
          out_pct_nxt   = held_r[LEVEL_W-1:8];
          out_avg_nxt   = avg_r;
          st_nxt        = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      gain_r      <= GAIN_RESET;
      holdoff_r   <= HOLDOFF_RESET;
      avg_r       <= '0;
      held_r      <= '0;
      ref_light_r <= '0;
      ref_level_r <= '0;
      pending_r   <= 1'b1;
      ticks_r     <= TICK_MAX;
      wr_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      gain_r      <= gain_nxt;
      holdoff_r   <= holdoff_nxt;
      avg_r       <= avg_nxt;
      held_r      <= held_nxt;
      ref_light_r <= ref_light_nxt;
      ref_level_r <= ref_level_nxt;
      pending_r   <= pending_nxt;
      ticks_r     <= ticks_nxt;
      wr_r        <= wr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    light_r   <= light_nxt;
    target_r  <= target_nxt;
    out_wr_r  <= out_wr_nxt;
    out_pct_r <= out_pct_nxt;
    out_avg_r <= out_avg_nxt;
  end

  assign in_ready              = (st_r == ST_IDLE);
  assign cfg_ready             = 1'b1;
  assign out_valid             = out_valid_r;
  assign out_write_level       = out_wr_r;
  assign out_backlight_percent = out_pct_r;
  assign out_smoothed_target   = out_avg_r;

endmodule

// File: rtl/albc_checker.sv
// port-level checks of the ambient light backlight controller
// depends on albc_pkg; bound to ambient_light_backlight_controller_top
module albc_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         out_write_level,
  input logic [albc_pkg::PCT_W-1:0]   out_backlight_percent,
  input logic [albc_pkg::LEVEL_W-1:0] out_smoothed_target
);
  import albc_pkg::*;

  // one request at a time: ready drops after each accepted request
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready stayed high after a request was taken");

  // a stalled response holds
  a_resp_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_write_level)
      && $stable(out_backlight_percent) && $stable(out_smoothed_target)))
    else $error("stalled response changed");

  // held level never above full scale
  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_backlight_percent <= PCT_MAX))
    else $error("backlight percent above 100");

  // average never above full scale
  a_avg_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_smoothed_target <= FULL_LEVEL))
    else $error("smoothed target above full level");

endmodule

bind ambient_light_backlight_controller_top albc_checker u_albc_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_valid),
  .in_ready             (in_ready),
  .out_valid            (out_valid),
  .out_ready            (out_ready),
  .out_write_level      (out_write_level),
  .out_backlight_percent(out_backlight_percent),
  .out_smoothed_target  (out_smoothed_target)
);

// File: verif/ambient_light_backlight_controller_top_tb.sv
`timescale 1ns / 100ps
// self-checking testbench of ambient_light_backlight_controller_top: scripted and random
// requests with random idling, checked against a built-in predictor of the controller
// depends on albc_pkg and the rtl of the block
module ambient_light_backlight_controller_top_tb;
  import albc_pkg::*;

  localparam int unsigned CLK_PERIOD   = 10;
  localparam int unsigned RESET_CYCLES = 12;
  localparam int unsigned LIGHT_W      = LIGHT_BITS_DEF;
  // one step of the buttons in q7.8
  localparam int unsigned STEP_LEVEL   = STEP_PERCENT_DEF * 256;
  // idle cycles seen before a register write or a forced pause goes out
  localparam int unsigned SETTLE_CYCLES = 8;
  // cycles run after the last report is back, before the end of the run
  localparam int unsigned TAIL_CYCLES   = 100;
  localparam int unsigned DRAIN_LIMIT   = 5000;
  localparam int unsigned CYCLE_LIMIT   = 1000000;

  // action codes with no meaning, the block must leave its state alone
  localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd5;
  localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;
  // register index outside the map, writes to it are dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef enum logic [1:0] {
    EV_REQUEST,
    EV_CONFIG,
    EV_PAUSE
  } script_kind_t;

  // one line of the stimulus script
  typedef struct {
    script_kind_t          kind;
    int unsigned           pre_gap;
    logic [ACT_W-1:0]      action;
    logic [LIGHT_W-1:0]    light;
    logic [EXT_W-1:0]      ext;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } script_line_t;

  // what the panel side should see for one request
  typedef struct packed {
    logic               written;
    logic [PCT_W-1:0]   percent;
    logic [LEVEL_W-1:0] average;
  } panel_report_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid          = 1'b0;
  logic                  in_ready;
  logic [ACT_W-1:0]      in_action         = '0;
  logic [LIGHT_W-1:0]    in_light_level    = '0;
  logic [EXT_W-1:0]      in_external_level = '0;
  logic                  out_valid;
  logic                  out_ready         = 1'b0;
  logic                  out_write_level;
  logic [PCT_W-1:0]      out_backlight_percent;
  logic [LEVEL_W-1:0]    out_smoothed_target;
  logic                  cfg_valid         = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index         = '0;
  logic [CFG_DATA_W-1:0] cfg_data          = '0;

  script_line_t  event_script_q[$];
  panel_report_t panel_reports_q[$];
  int unsigned   fail_count  = 0;
  int unsigned   cycle_count = 0;

  // shadow of the controller state and its registers
  logic [LEVEL_W-1:0] m_average;
  logic [LEVEL_W-1:0] m_held;
  logic [LIGHT_W-1:0] m_ref_light;
  logic [LEVEL_W-1:0] m_ref_level;
  logic               m_renorm;
  logic [TICK_W-1:0]  m_ticks;
  logic [GAIN_W-1:0]  m_gain;
  logic [TICK_W-1:0]  m_holdoff;

  always #(CLK_PERIOD / 2) clk = ~clk;

  ambient_light_backlight_controller_top dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_action             (in_action),
    .in_light_level        (in_light_level),
    .in_external_level     (in_external_level),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_write_level       (out_write_level),
    .out_backlight_percent (out_backlight_percent),
    .out_smoothed_target   (out_smoothed_target),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic void clear_shadow();
    m_average   = '0;
    m_held      = '0;
    m_ref_light = '0;
    m_ref_level = '0;
    m_renorm    = 1'b1;
    m_ticks     = TICK_MAX;
    m_gain      = GAIN_RESET;
    m_holdoff   = HOLDOFF_RESET;
  endfunction

  function automatic void apply_register(input logic [CFG_IDX_W-1:0]  idx,
                                         input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_GAIN:    m_gain    = (data > GAIN_ONE) ? GAIN_ONE : data[GAIN_W-1:0];
      CFG_HOLDOFF: m_holdoff = data[TICK_W-1:0];
      default: ;
    endcase
  endfunction

  // new level goes to the panel only if it moves by a full percent
  function automatic logic commit_level(input logic [LEVEL_W-1:0] lvl);
    int unsigned diff;
    diff = (lvl > m_held) ? lvl - m_held : m_held - lvl;
    if (diff < ONE_PERCENT) return 1'b0;
    m_held  = lvl;
    m_ticks = '0;
    return 1'b1;
  endfunction

  function automatic panel_report_t advance_backlight(input logic [ACT_W-1:0]   act,
                                                     input logic [LIGHT_W-1:0] light,
                                                     input logic [EXT_W-1:0]   ext);
    panel_report_t      rpt;
    logic [63:0]        scaled;
    logic [63:0]        acc;
    logic [LEVEL_W-1:0] target;
    logic [EXT_W-1:0]   clipped;
    int unsigned        level;
    rpt.written = 1'b0;
    case (act)
      ACT_SAMPLE: begin
        // first sample after reset or a manual change sets the reference
        if (m_renorm) begin
          m_average   = m_held;
          m_ref_light = light;
          m_ref_level = m_held;
          m_renorm    = 1'b0;
        end
        if (m_ref_light == '0) begin
          target = FULL_LEVEL;
        end else begin
          scaled = (64'(light) * 64'(m_ref_level)) / 64'(m_ref_light);
          target = (scaled > 64'(FULL_LEVEL)) ? FULL_LEVEL : scaled[LEVEL_W-1:0];
        end
        acc = 64'(m_gain) * 64'(target)
            + (64'(GAIN_ONE) - 64'(m_gain)) * 64'(m_average) + 64'd32768;
        acc = acc >> 16;
        m_average   = (acc > 64'(FULL_LEVEL)) ? FULL_LEVEL : acc[LEVEL_W-1:0];
        rpt.written = commit_level(m_average);
      end
      ACT_STEP_UP: begin
        level = m_held + STEP_LEVEL;
        if (level > FULL_LEVEL) level = FULL_LEVEL;
        rpt.written = commit_level(LEVEL_W'(level));
        m_renorm    = 1'b1;
      end
      ACT_STEP_DOWN: begin
        level = (m_held >= STEP_LEVEL) ? m_held - STEP_LEVEL : 0;
        rpt.written = commit_level(LEVEL_W'(level));
        m_renorm    = 1'b1;
      end
      ACT_EXTERNAL: begin
        // another agent only wins once our own write has settled
        if (m_ticks >= m_holdoff) begin
          clipped  = (ext > PCT_MAX) ? PCT_MAX : ext;
          m_held   = LEVEL_W'(clipped) * ONE_PERCENT;
          m_renorm = 1'b1;
        end
      end
      ACT_TICK: begin
        if (m_ticks != TICK_MAX) m_ticks = m_ticks + 1'b1;
      end
      default: ;
    endcase
    rpt.percent = PCT_W'(m_held >> 8);
    rpt.average = m_average;
    return rpt;
  endfunction

  // ---------------------------------------------------------------------------
  // random helpers
  // ---------------------------------------------------------------------------

  // mostly back to back or short, now and then a long hole
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 120);
  endfunction

  // luminance spread over all magnitudes so targets land both below and above the cap
  function automatic logic [LIGHT_W-1:0] rand_light();
    int unsigned r;
    int unsigned k;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r < 7) return LIGHT_W'($urandom());
    k = $urandom_range(1, LIGHT_W);
    return LIGHT_W'($urandom() & ((64'd1 << k) - 1));
  endfunction

  function automatic logic [EXT_W-1:0] rand_ext();
    if ($urandom_range(0, 3) != 0) return EXT_W'($urandom_range(0, PCT_MAX));
    return EXT_W'($urandom_range(PCT_MAX + 1, (1 << EXT_W) - 1));
  endfunction

  function automatic logic [ACT_W-1:0] rand_action();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return ACT_SAMPLE;
    if (r < 52) return ACT_STEP_UP;
    if (r < 64) return ACT_STEP_DOWN;
    if (r < 74) return ACT_EXTERNAL;
    if (r < 95) return ACT_TICK;
    return ACT_W'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
  endfunction

  // ---------------------------------------------------------------------------
  // script building
  // ---------------------------------------------------------------------------

  task automatic queue_request(input logic [ACT_W-1:0]   act,
                               input logic [LIGHT_W-1:0] light,
                               input logic [EXT_W-1:0]   ext,
                               input int unsigned        gap);
    script_line_t ln;
    ln.kind    = EV_REQUEST;
    ln.pre_gap = gap;
    ln.action  = act;
    ln.light   = light;
    ln.ext     = ext;
    ln.idx     = '0;
    ln.data    = '0;
    event_script_q.push_back(ln);
  endtask

  // register writes and pauses both wait for the block to go quiet
  task automatic queue_quiet_line(input script_kind_t          kind,
                                  input logic [CFG_IDX_W-1:0]  idx,
                                  input logic [CFG_DATA_W-1:0] data);
    script_line_t ln;
    ln.kind    = kind;
    ln.pre_gap = 0;
    ln.action  = '0;
    ln.light   = '0;
    ln.ext     = '0;
    ln.idx     = idx;
    ln.data    = data;
    event_script_q.push_back(ln);
  endtask

  task automatic queue_random_requests(input int unsigned count, input bit with_gaps,
                                       input bit with_pause);
    for (int unsigned i = 0; i < count; i++) begin
      // sender holds off until every report is back, then carries on
      if (with_pause && i == count / 2) queue_quiet_line(EV_PAUSE, '0, '0);
      queue_request(rand_action(), rand_light(), rand_ext(), with_gaps ? gap_len() : 0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // request and register driver
  // ---------------------------------------------------------------------------

  int unsigned gap_count;
  int unsigned idle_cycles;

  always @(posedge clk) begin : request_driver
    logic         nxt_in_valid;
    logic         nxt_cfg_valid;
    script_line_t ln;
    nxt_in_valid  = in_valid;
    nxt_cfg_valid = cfg_valid;
    if (!rst_n) begin
      nxt_in_valid  = 1'b0;
      nxt_cfg_valid = 1'b0;
      gap_count     = 0;
      idle_cycles   = 0;
      clear_shadow();
    end else begin
      // predict at the accepting edge, with the payload that was on the wires
      if (in_valid && in_ready) begin
        panel_reports_q.push_back(advance_backlight(in_action, in_light_level,
                                                    in_external_level));
        nxt_in_valid = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        apply_register(cfg_index, cfg_data);
        nxt_cfg_valid = 1'b0;
      end
      // block counts as quiet once no request and no report are in flight
      if (panel_reports_q.size() == 0 && !in_valid) idle_cycles++;
      else idle_cycles = 0;
      // next script line, loaded in the same edge so back to back requests stay high
      if (!nxt_in_valid && !nxt_cfg_valid && event_script_q.size() != 0) begin
        ln = event_script_q[0];
        if (gap_count < ln.pre_gap) begin
          gap_count++;
        end else if (ln.kind == EV_REQUEST) begin
          void'(event_script_q.pop_front());
          in_action         <= ln.action;
          in_light_level    <= ln.light;
          in_external_level <= ln.ext;
          nxt_in_valid      = 1'b1;
          gap_count         = 0;
        end else if (idle_cycles >= SETTLE_CYCLES) begin
          void'(event_script_q.pop_front());
          gap_count = 0;
          if (ln.kind == EV_CONFIG) begin
            cfg_index     <= ln.idx;
            cfg_data      <= ln.data;
            nxt_cfg_valid = 1'b1;
          end
        end
      end
    end
    in_valid  <= nxt_in_valid;
    cfg_valid <= nxt_cfg_valid;
  end

  // ---------------------------------------------------------------------------
  // report monitor with random back pressure
  // ---------------------------------------------------------------------------

  int unsigned stall_left;
  int unsigned run_left;

  always @(posedge clk) begin : report_monitor
    logic          nxt_ready;
    panel_report_t want;
    if (!rst_n) begin
      nxt_ready  = 1'b0;
      stall_left = 0;
      run_left   = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (panel_reports_q.size() == 0) begin
          $error("report with no request outstanding");
          fail_count++;
        end else begin
          want = panel_reports_q.pop_front();
          if (out_write_level !== want.written) begin
            $error("write_level: expected %0d, got %0d", want.written, out_write_level);
            fail_count++;
          end
          if (out_backlight_percent !== want.percent) begin
            $error("backlight_percent: expected %0d, got %0d", want.percent,
                   out_backlight_percent);
            fail_count++;
          end
          if (out_smoothed_target !== want.average) begin
            $error("smoothed_target: expected %0d, got %0d", want.average,
                   out_smoothed_target);
            fail_count++;
          end
        end
      end
      // alternate stalls and ready runs; some runs are long with no stall at all
      if (stall_left != 0) begin
        stall_left--;
        nxt_ready = 1'b0;
      end else begin
        nxt_ready = 1'b1;
        if (run_left != 0) begin
          run_left--;
        end else begin
          run_left   = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(0, 6);
          stall_left = gap_len();
        end
      end
    end
    out_ready <= nxt_ready;
  end

  // ---------------------------------------------------------------------------
  // watchdog
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // script and end of run
  // ---------------------------------------------------------------------------

  initial begin : run_script
    int unsigned drain_cycles;

    // directed part with the reset register values
    // tick right after reset stays saturated
    queue_request(ACT_TICK, '0, '0, 0);
    // external above 100 taken as full, outside the hold-off window
    queue_request(ACT_EXTERNAL, '0, 7'h7F, 0);
    // step up at full scale: clamped, nothing written, renormalize still set
    queue_request(ACT_STEP_UP, '1, '0, 0);
    // brightest light becomes the reference
    queue_request(ACT_SAMPLE, '1, '0, 0);
    // darkness pulls the average down far enough to write
    queue_request(ACT_SAMPLE, '0, '0, 1);
    // inside the hold-off window after our own write: ignored
    queue_request(ACT_EXTERNAL, 24'h5A5A5A, 7'd40, 0);
    queue_request(ACT_TICK, '0, '1, 2);
    queue_request(ACT_STEP_DOWN, '0, '0, 0);
    queue_request(ACT_STEP_UP, '0, '0, 0);
    // unused action codes leave everything alone
    queue_request(ACT_SPARE_LO, LIGHT_W'($urandom()), EXT_W'($urandom()), 0);
    queue_request(ACT_W'(ACT_SPARE_LO + 1), LIGHT_W'($urandom()), EXT_W'($urandom()), 0);
    queue_request(ACT_SPARE_HI, '1, '1, 0);

    // no hold-off, gain beyond one saturates to one
    queue_quiet_line(EV_CONFIG, CFG_HOLDOFF, '0);
    queue_quiet_line(EV_CONFIG, CFG_GAIN, '1);
    queue_request(ACT_EXTERNAL, '0, 7'd0, 0);
    // step down at zero: clamped, no write
    queue_request(ACT_STEP_DOWN, '0, '0, 0);
    // zero reference level gives a zero target
    queue_request(ACT_SAMPLE, 24'd777, '0, 0);
    queue_request(ACT_EXTERNAL, '0, PCT_MAX, 0);
    queue_request(ACT_EXTERNAL, '0, 7'd0, 0);
    // zero reference light gives a full target
    queue_request(ACT_SAMPLE, '0, '0, 0);
    queue_request(ACT_SAMPLE, 24'hABCDEF, '0, 0);

    // short hold-off: external ignored, then taken after enough ticks
    queue_quiet_line(EV_CONFIG, CFG_HOLDOFF, 17'd3);
    queue_quiet_line(EV_CONFIG, CFG_GAIN, 17'd32768);
    queue_request(ACT_STEP_DOWN, '0, '0, 0);
    queue_request(ACT_EXTERNAL, '0, 7'd55, 0);
    for (int i = 0; i < 3; i++) queue_request(ACT_TICK, '0, '0, 0);
    queue_request(ACT_EXTERNAL, '0, 7'd55, 0);

    // random part, a different register setting for each stretch
    queue_quiet_line(EV_CONFIG, CFG_GAIN, CFG_DATA_W'(GAIN_RESET));
    queue_quiet_line(EV_CONFIG, CFG_HOLDOFF, CFG_DATA_W'($urandom_range(0, 50)));
    queue_random_requests(80, 1'b1, 1'b0);

    // frozen average and the longest hold-off, sender never idles
    queue_quiet_line(EV_CONFIG, CFG_GAIN, '0);
    queue_quiet_line(EV_CONFIG, CFG_HOLDOFF, CFG_DATA_W'(TICK_MAX) | 17'h10000);
    queue_random_requests(50, 1'b0, 1'b0);

    // average jumps straight to the target
    queue_quiet_line(EV_CONFIG, CFG_GAIN, CFG_DATA_W'(GAIN_ONE));
    queue_quiet_line(EV_CONFIG, CFG_HOLDOFF, '0);
    queue_random_requests(90, 1'b1, 1'b1);

    // slowest possible average
    queue_quiet_line(EV_CONFIG, CFG_GAIN, 17'd1);
    queue_quiet_line(EV_CONFIG, CFG_HOLDOFF, 17'd1);
    queue_random_requests(60, 1'b1, 1'b0);

    // random gain, dropped write to an unmapped index
    queue_quiet_line(EV_CONFIG, CFG_GAIN, CFG_DATA_W'($urandom_range(0, GAIN_ONE)));
    queue_quiet_line(EV_CONFIG, CFG_HOLDOFF, CFG_DATA_W'($urandom_range(0, 20)));
    queue_quiet_line(EV_CONFIG, CFG_SPARE, CFG_DATA_W'($urandom()));
    queue_random_requests(120, 1'b1, 1'b0);

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // script fully sent
    while (event_script_q.size() != 0 || in_valid || cfg_valid) @(posedge clk);
    // every report back, bounded
    drain_cycles = 0;
    while (panel_reports_q.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      drain_cycles++;
    end
    if (panel_reports_q.size() != 0) begin
      $error("%0d reports never arrived", panel_reports_q.size());
      fail_count++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/albc_pkg.sv
rtl/albc_muldiv.sv
rtl/ambient_light_backlight_controller_top.sv
rtl/albc_checker.sv
verif/ambient_light_backlight_controller_top_tb.sv
